// ===== rtl/afd_pkg.sv =====
// shared types, constants and register map of the detection decode unit
package afd_pkg;

    localparam int DefMaxClasses = 128;
    localparam int DefMaxGrid    = 256;

    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 31;

    localparam logic [CfgIndexW-1:0] RegClassScale     = 3'd0;
    localparam logic [CfgIndexW-1:0] RegClassZeroPoint = 3'd1;
    localparam logic [CfgIndexW-1:0] RegBoxScale       = 3'd2;
    localparam logic [CfgIndexW-1:0] RegBoxZeroPoint   = 3'd3;
    localparam logic [CfgIndexW-1:0] RegScoreThreshold = 3'd4;
    localparam logic [CfgIndexW-1:0] RegStrideShift    = 3'd5;

    localparam logic [19:0]        ClassScaleRst     = 20'd65536;
    localparam logic signed [7:0]  ClassZeroPointRst = 8'sd0;
    localparam logic [19:0]        BoxScaleRst       = 20'd65536;
    localparam logic signed [7:0]  BoxZeroPointRst   = 8'sd0;
    localparam logic signed [30:0] ScoreThresholdRst = 31'sd16384;
    localparam logic [2:0]         StrideShiftRst    = 3'd3;

    localparam logic [2:0] StrideShiftMin = 3'd3;
    localparam logic [2:0] StrideShiftMax = 3'd5;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);

    typedef struct packed {
        logic [19:0]        class_scale;
        logic signed [7:0]  class_zero_point;
        logic [19:0]        box_scale;
        logic signed [7:0]  box_zero_point;
        logic signed [30:0] score_threshold;
        logic [2:0]         stride_shift;
    } afd_cfg_t;

    typedef struct packed {
        logic [7:0]         grid_x;
        logic [7:0]         grid_y;
        logic signed [7:0]  box_left;
        logic signed [7:0]  box_top;
        logic signed [7:0]  box_right;
        logic signed [7:0]  box_bottom;
        logic signed [30:0] score;
        logic [6:0]         class_index;
    } afd_job_t;

    typedef struct packed {
        logic push;
    } afd_qctl_t;

endpackage

// ===== rtl/afd_in_if.sv =====
// input channel carrying one class score transaction of a grid cell
interface afd_in_if;
    logic              valid;
    logic              ready;
    logic [7:0]        grid_x;
    logic [7:0]        grid_y;
    logic signed [7:0] score_code;
    logic signed [7:0] box_left;
    logic signed [7:0] box_top;
    logic signed [7:0] box_right;
    logic signed [7:0] box_bottom;
    logic              last_class;

    modport source (
        output valid, grid_x, grid_y, score_code, box_left, box_top, box_right,
               box_bottom, last_class,
        input  ready
    );
    modport sink (
        input  valid, grid_x, grid_y, score_code, box_left, box_top, box_right,
               box_bottom, last_class,
        output ready
    );
endinterface

// ===== rtl/afd_out_if.sv =====
// output channel carrying one detection transaction
interface afd_out_if;
    logic               valid;
    logic               ready;
    logic signed [36:0] box_x;
    logic signed [36:0] box_y;
    logic signed [36:0] box_w;
    logic signed [36:0] box_h;
    logic signed [30:0] score;
    logic [6:0]         class_index;

    modport source (
        output valid, box_x, box_y, box_w, box_h, score, class_index,
        input  ready
    );
    modport sink (
        input  valid, box_x, box_y, box_w, box_h, score, class_index,
        output ready
    );
endinterface

// ===== rtl/afd_front.sv =====
// front end: score dequantization, threshold and running maximum per cell
module afd_front #(
    parameter int MAX_CLASSES = afd_pkg::DefMaxClasses
) (
    input  logic                clk,
    input  logic                rst_n,
    afd_in_if.sink              det_in,
    input  afd_pkg::afd_cfg_t   cfg,
    input  logic                q_full,
    output afd_pkg::afd_qctl_t  q_ctl,
    output afd_pkg::afd_job_t   q_job
);

    localparam int CntLimit = (MAX_CLASSES - 1) < 127 ? (MAX_CLASSES - 1) : 127;

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_last_reg;
    logic signed [30:0] s1_score_reg;
    logic [7:0]         s1_grid_x_reg, s1_grid_y_reg;
    logic signed [7:0]  s1_left_reg, s1_top_reg, s1_right_reg, s1_bottom_reg;

    logic signed [30:0] best_score_reg, best_score_next;
    logic [6:0]         best_class_reg, best_class_next;
    logic [6:0]         class_counter_reg, class_counter_next;
    logic               any_qualified_reg, any_qualified_next;

    logic               in_accept;
    logic               s1_go;
    logic               qualified;
    logic               take;
    logic               any_now;
    logic signed [8:0]  score_diff;
    logic signed [30:0] score_prod;

    assign s1_go        = !(s1_last_reg && q_full);
    assign det_in.ready = !s1_valid_reg || s1_go;
    assign in_accept    = det_in.valid && det_in.ready;

    assign score_diff = 9'(det_in.score_code) - 9'(cfg.class_zero_point);
    assign score_prod = score_diff * $signed({1'b0, cfg.class_scale});

    assign qualified = s1_score_reg >= cfg.score_threshold;
    assign take      = qualified && (!any_qualified_reg || s1_score_reg > best_score_reg);
    assign any_now   = any_qualified_reg || qualified;

    always_comb
    begin
        s1_valid_next      = s1_valid_reg;
        best_score_next    = best_score_reg;
        best_class_next    = best_class_reg;
        class_counter_next = class_counter_reg;
        any_qualified_next = any_qualified_reg;
        if (s1_valid_reg && s1_go)
        begin
            s1_valid_next = 1'b0;
            if (s1_last_reg)
            begin
                best_score_next    = '0;
                best_class_next    = '0;
                class_counter_next = '0;
                any_qualified_next = 1'b0;
            end
            else
            begin
                if (take)
                begin
                    best_score_next = s1_score_reg;
                    best_class_next = class_counter_reg;
                end
                any_qualified_next = any_now;
                if (class_counter_reg < 7'(CntLimit))
                begin
                    class_counter_next = class_counter_reg + 7'd1;
                end
            end
        end
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            best_score_reg    <= '0;
            best_class_reg    <= '0;
            class_counter_reg <= '0;
            any_qualified_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg      <= s1_valid_next;
            best_score_reg    <= best_score_next;
            best_class_reg    <= best_class_next;
            class_counter_reg <= class_counter_next;
            any_qualified_reg <= any_qualified_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_last_reg   <= det_in.last_class;
            s1_score_reg  <= score_prod;
            s1_grid_x_reg <= det_in.grid_x;
            s1_grid_y_reg <= det_in.grid_y;
            s1_left_reg   <= det_in.box_left;
            s1_top_reg    <= det_in.box_top;
            s1_right_reg  <= det_in.box_right;
            s1_bottom_reg <= det_in.box_bottom;
        end
    end

    // detection leaves on the last class when anything qualified
    assign q_ctl.push = s1_valid_reg && s1_go && s1_last_reg && any_now;

    assign q_job.grid_x      = s1_grid_x_reg;
    assign q_job.grid_y      = s1_grid_y_reg;
    assign q_job.box_left    = s1_left_reg;
    assign q_job.box_top     = s1_top_reg;
    assign q_job.box_right   = s1_right_reg;
    assign q_job.box_bottom  = s1_bottom_reg;
    assign q_job.score       = take ? s1_score_reg : best_score_reg;
    assign q_job.class_index = take ? class_counter_reg : best_class_reg;

endmodule

// ===== rtl/afd_queue.sv =====
// short queue of pending detections between front and back end
module afd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  afd_pkg::afd_qctl_t q_ctl,
    input  afd_pkg::afd_job_t  push_job,
    input  logic               pop,
    output logic               full,
    output logic               not_empty,
    output afd_pkg::afd_job_t  pop_job
);

    localparam int CntW = afd_pkg::QueuePtrW + 1;

    afd_pkg::afd_job_t mem [afd_pkg::QueueDepth];

    logic [afd_pkg::QueuePtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [afd_pkg::QueuePtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]               count_reg, count_next;

    assign full      = count_reg == CntW'(afd_pkg::QueueDepth);
    assign not_empty = count_reg != '0;
    assign pop_job   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_ctl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == afd_pkg::QueuePtrW'(afd_pkg::QueueDepth - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == afd_pkg::QueuePtrW'(afd_pkg::QueueDepth - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({q_ctl.push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_ctl.push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/afd_back.sv =====
// back end: distance dequantization, box edges and stride scaling
module afd_back #(
    parameter int MAX_GRID = afd_pkg::DefMaxGrid
) (
    input  logic               clk,
    input  logic               rst_n,
    input  afd_pkg::afd_cfg_t  cfg,
    input  logic               job_valid,
    input  afd_pkg::afd_job_t  job,
    output logic               pop,
    afd_out_if.source          det_out
);

    logic               a_valid_reg, a_valid_next;
    logic signed [31:0] a_cx_reg, a_cy_reg;
    logic signed [30:0] a_dl_reg, a_dt_reg, a_dr_reg, a_db_reg;
    logic signed [30:0] a_score_reg;
    logic [6:0]         a_class_reg;

    logic               out_valid_reg, out_valid_next;
    logic signed [36:0] out_x_reg, out_y_reg, out_w_reg, out_h_reg;
    logic signed [30:0] out_score_reg;
    logic [6:0]         out_class_reg;

    logic               a_ready, b_ready;
    logic [7:0]         gx, gy;
    logic signed [8:0]  dl_diff, dt_diff, dr_diff, db_diff;
    logic signed [21:0] bscale;
    logic signed [31:0] x0, y0, w, h;
    logic [2:0]         sh;

    function automatic logic [7:0] clamp_grid(input logic [7:0] g);
        logic [7:0] r;
        r = g;
        if (int'(g) > MAX_GRID - 1)
        begin
            r = 8'(MAX_GRID - 1);
        end
        return r;
    endfunction

    assign b_ready = !out_valid_reg || det_out.ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign pop     = job_valid && a_ready;

    assign gx      = clamp_grid(job.grid_x);
    assign gy      = clamp_grid(job.grid_y);
    assign bscale  = $signed({2'b00, cfg.box_scale});
    assign dl_diff = 9'(job.box_left)   - 9'(cfg.box_zero_point);
    assign dt_diff = 9'(job.box_top)    - 9'(cfg.box_zero_point);
    assign dr_diff = 9'(job.box_right)  - 9'(cfg.box_zero_point);
    assign db_diff = 9'(job.box_bottom) - 9'(cfg.box_zero_point);

    always_comb
    begin
        sh = cfg.stride_shift;
        if (sh < afd_pkg::StrideShiftMin)
        begin
            sh = afd_pkg::StrideShiftMin;
        end
        else if (sh > afd_pkg::StrideShiftMax)
        begin
            sh = afd_pkg::StrideShiftMax;
        end
    end

    assign x0 = a_cx_reg - 32'(a_dl_reg);
    assign y0 = a_cy_reg - 32'(a_dt_reg);
    assign w  = 32'(a_dl_reg) + 32'(a_dr_reg);
    assign h  = 32'(a_dt_reg) + 32'(a_db_reg);

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (a_ready)
        begin
            a_valid_next = job_valid;
        end
        out_valid_next = out_valid_reg;
        if (b_ready)
        begin
            out_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            // cell centre is grid index plus one half
            a_cx_reg    <= $signed({8'd0, gx, 16'h8000});
            a_cy_reg    <= $signed({8'd0, gy, 16'h8000});
            a_dl_reg    <= dl_diff * bscale;
            a_dt_reg    <= dt_diff * bscale;
            a_dr_reg    <= dr_diff * bscale;
            a_db_reg    <= db_diff * bscale;
            a_score_reg <= job.score;
            a_class_reg <= job.class_index;
        end
        if (a_valid_reg && b_ready)
        begin
            out_x_reg     <= 37'(x0) <<< sh;
            out_y_reg     <= 37'(y0) <<< sh;
            out_w_reg     <= 37'(w) <<< sh;
            out_h_reg     <= 37'(h) <<< sh;
            out_score_reg <= a_score_reg;
            out_class_reg <= a_class_reg;
        end
    end

    assign det_out.valid       = out_valid_reg;
    assign det_out.box_x       = out_x_reg;
    assign det_out.box_y       = out_y_reg;
    assign det_out.box_w       = out_w_reg;
    assign det_out.box_h       = out_h_reg;
    assign det_out.score       = out_score_reg;
    assign det_out.class_index = out_class_reg;

endmodule

// ===== rtl/anchor_free_detection_decode_unit.sv =====
// Anchor-free detection decode: takes one int8 class score per clock and per
// cell, keeps the best score at or above threshold, and on the last class of
// a cell hands a detection (box edges, score, class) to a four-entry
// queue that feeds the box arithmetic. Throughput is one transaction per
// clock; after its last class score is accepted, a detection passes the
// queue write, the distance multiply stage and the output register. Input
// stalls only when the last class of a cell meets a full queue, i.e. after
// the output side has held off six pending detections (four queued, two in
// the back end stages). Configuration is written through cfg_we, cfg_index
// and cfg_wdata, by the user only while idle; the block does not enforce it.
module anchor_free_detection_decode_unit #(
    parameter int MAX_CLASSES = afd_pkg::DefMaxClasses,
    parameter int MAX_GRID    = afd_pkg::DefMaxGrid
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [afd_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [afd_pkg::CfgDataW-1:0]  cfg_wdata,
    afd_in_if.sink                        det_in,
    afd_out_if.source                     det_out
);

    afd_pkg::afd_cfg_t  cfg_reg;
    afd_pkg::afd_qctl_t q_ctl;
    afd_pkg::afd_job_t  push_job, pop_job;
    logic               q_full, q_not_empty, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.class_scale      <= afd_pkg::ClassScaleRst;
            cfg_reg.class_zero_point <= afd_pkg::ClassZeroPointRst;
            cfg_reg.box_scale        <= afd_pkg::BoxScaleRst;
            cfg_reg.box_zero_point   <= afd_pkg::BoxZeroPointRst;
            cfg_reg.score_threshold  <= afd_pkg::ScoreThresholdRst;
            cfg_reg.stride_shift     <= afd_pkg::StrideShiftRst;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                afd_pkg::RegClassScale:     cfg_reg.class_scale      <= cfg_wdata[19:0];
                afd_pkg::RegClassZeroPoint: cfg_reg.class_zero_point <= cfg_wdata[7:0];
                afd_pkg::RegBoxScale:       cfg_reg.box_scale        <= cfg_wdata[19:0];
                afd_pkg::RegBoxZeroPoint:   cfg_reg.box_zero_point   <= cfg_wdata[7:0];
                afd_pkg::RegScoreThreshold: cfg_reg.score_threshold  <= cfg_wdata[30:0];
                afd_pkg::RegStrideShift:    cfg_reg.stride_shift     <= cfg_wdata[2:0];
                default:                    ;
            endcase
        end
    end

    afd_front #(
        .MAX_CLASSES(MAX_CLASSES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .det_in (det_in),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .q_ctl  (q_ctl),
        .q_job  (push_job)
    );

    afd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_ctl     (q_ctl),
        .push_job  (push_job),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop_job   (pop_job)
    );

    afd_back #(
        .MAX_GRID(MAX_GRID)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (q_not_empty),
        .job       (pop_job),
        .pop       (q_pop),
        .det_out   (det_out)
    );

endmodule
